### rtl/skt_pkg.sv
// shared types and codes for the sorted key table
package skt_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2
  } skt_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MISSING   = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } skt_status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } skt_state_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic capture;
    logic insert;
    logic remove;
  } skt_cmd_t;

endpackage

### rtl/sorted_key_table.sv
// sorted key table top level: control, result register and the row of cells
//
// channel  direction  handshake               payload
// in       request    in_valid_i / in_stall_o operation_i, search_key_i, entry_data_i
// out      result     out_valid_o / out_stall_i status_o, found_data_o,
//                                             entry_position_o, entry_count_o
//
// one request at a time: every cell compares its key at the accept edge; the
// execute state then shifts the row and loads the result register. the result
// waits in its register; a stalled result holds the execute state.
// reset clears the entry count and handshake state; cell contents stay as is.
module sorted_key_table #(
  parameter int CAPACITY  = 64,
  parameter int KEY_BITS  = 32,
  parameter int DATA_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    operation_i,
  input  logic [KEY_BITS-1:0]           search_key_i,
  input  logic [DATA_BITS-1:0]          entry_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [DATA_BITS-1:0]          found_data_o,
  output logic [$clog2(CAPACITY)-1:0]   entry_position_o,
  output logic [$clog2(CAPACITY+1)-1:0] entry_count_o
);

  localparam int POS_BITS = $clog2(CAPACITY);
  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  skt_pkg::skt_state_e  state_q, state_d;
  skt_pkg::skt_cmd_t    cmd;
  logic [CNT_BITS-1:0]  count_q, count_d;
  logic [1:0]           op_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [DATA_BITS-1:0] dat_q;
  logic                 out_valid_q, out_valid_d;
  logic [1:0]           status_q, status_d;
  logic [DATA_BITS-1:0] found_q, found_d;
  logic [POS_BITS-1:0]  pos_q, pos_d;
  logic [CNT_BITS-1:0]  cnt_out_q;

  logic                 accept;
  logic                 exec_go;
  logic                 hit;
  logic                 full;
  logic                 ins_ok;
  logic                 del_ok;

  logic [CAPACITY-1:0]  occ;
  logic [CAPACITY-1:0]  lt;
  logic [CAPACITY-1:0]  eq;
  logic [CAPACITY-1:0]  boundary;
  logic [KEY_BITS-1:0]  cell_key  [CAPACITY];
  logic [DATA_BITS-1:0] cell_data [CAPACITY];
  logic [POS_BITS-1:0]  eq_pos;
  logic [POS_BITS-1:0]  ins_pos;
  logic [DATA_BITS-1:0] eq_data;

  assign accept  = in_valid_i && !in_stall_o;
  assign exec_go = (state_q == skt_pkg::S_EXEC) && !(out_valid_q && out_stall_i);
  assign hit     = |eq;
  assign full    = (count_q == CNT_BITS'(CAPACITY));
  assign ins_ok  = (op_q == skt_pkg::OP_INSERT) && !hit && !full;
  assign del_ok  = (op_q == skt_pkg::OP_DELETE) && hit;

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                 left_lt;
    logic [KEY_BITS-1:0]  left_key;
    logic [DATA_BITS-1:0] left_data;
    logic [KEY_BITS-1:0]  right_key;
    logic [DATA_BITS-1:0] right_data;

    assign occ[i] = (CNT_BITS'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_lt   = 1'b1;
      assign left_key  = key_q;
      assign left_data = dat_q;
    end else begin : g_mid
      assign left_lt   = lt[i-1];
      assign left_key  = cell_key[i-1];
      assign left_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key  = cell_key[i];
      assign right_data = cell_data[i];
    end else begin : g_inner
      assign right_key  = cell_key[i+1];
      assign right_data = cell_data[i+1];
    end

    assign boundary[i] = !lt[i] && left_lt;

    skt_cell #(
      .KEY_BITS (KEY_BITS),
      .DATA_BITS(DATA_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .occ_i       (occ[i]),
      .search_key_i(search_key_i),
      .new_key_i   (key_q),
      .new_data_i  (dat_q),
      .left_lt_i   (left_lt),
      .left_key_i  (left_key),
      .left_data_i (left_data),
      .right_key_i (right_key),
      .right_data_i(right_data),
      .key_o       (cell_key[i]),
      .data_o      (cell_data[i]),
      .lt_o        (lt[i]),
      .eq_o        (eq[i])
    );
  end

  // one-hot to index, and data of the matching cell
  always_comb begin
    eq_pos  = '0;
    ins_pos = '0;
    eq_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (eq[i]) begin
        eq_pos  = eq_pos | POS_BITS'(i);
        eq_data = eq_data | cell_data[i];
      end
      if (boundary[i]) begin
        ins_pos = ins_pos | POS_BITS'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      skt_pkg::S_IDLE: begin
        if (accept) state_d = skt_pkg::S_EXEC;
      end
      skt_pkg::S_EXEC: begin
        if (exec_go) state_d = skt_pkg::S_IDLE;
      end
      default: state_d = skt_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o  = 1'b1;
    cmd.capture = 1'b0;
    cmd.insert  = 1'b0;
    cmd.remove  = 1'b0;
    unique case (state_q)
      skt_pkg::S_IDLE: begin
        in_stall_o  = 1'b0;
        cmd.capture = in_valid_i;
      end
      skt_pkg::S_EXEC: begin
        cmd.insert = exec_go && ins_ok;
        cmd.remove = exec_go && del_ok;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  // result and count
  always_comb begin
    status_d = skt_pkg::ST_MISSING;
    found_d  = '0;
    pos_d    = '0;
    count_d  = count_q;
    case (op_q)
      skt_pkg::OP_INSERT: begin
        if (hit) begin
          status_d = skt_pkg::ST_DUPLICATE;
          pos_d    = eq_pos;
        end else if (full) begin
          status_d = skt_pkg::ST_FULL;
        end else begin
          status_d = skt_pkg::ST_OK;
          pos_d    = ins_pos;
          count_d  = count_q + CNT_BITS'(1);
        end
      end
      skt_pkg::OP_DELETE: begin
        if (hit) begin
          status_d = skt_pkg::ST_OK;
          pos_d    = eq_pos;
          count_d  = count_q - CNT_BITS'(1);
        end
      end
      skt_pkg::OP_FIND: begin
        if (hit) begin
          status_d = skt_pkg::ST_OK;
          found_d  = eq_data;
          pos_d    = eq_pos;
        end
      end
      default: status_d = skt_pkg::ST_MISSING;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec_go) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= skt_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (exec_go) count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= operation_i;
      key_q <= search_key_i;
      dat_q <= entry_data_i;
    end
    if (exec_go) begin
      status_q  <= status_d;
      found_q   <= found_d;
      pos_q     <= pos_d;
      cnt_out_q <= count_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign found_data_o     = found_q;
  assign entry_position_o = pos_q;
  assign entry_count_o    = cnt_out_q;

endmodule

### rtl/skt_cell.sv
// one table slot: holds a key and data word, compares and shifts with its neighbors
module skt_cell #(
  parameter int KEY_BITS  = 32,
  parameter int DATA_BITS = 32
) (
  input  logic                 clk_i,
  input  skt_pkg::skt_cmd_t    cmd_i,
  input  logic                 occ_i,
  input  logic [KEY_BITS-1:0]  search_key_i,
  input  logic [KEY_BITS-1:0]  new_key_i,
  input  logic [DATA_BITS-1:0] new_data_i,
  input  logic                 left_lt_i,
  input  logic [KEY_BITS-1:0]  left_key_i,
  input  logic [DATA_BITS-1:0] left_data_i,
  input  logic [KEY_BITS-1:0]  right_key_i,
  input  logic [DATA_BITS-1:0] right_data_i,
  output logic [KEY_BITS-1:0]  key_o,
  output logic [DATA_BITS-1:0] data_o,
  output logic                 lt_o,
  output logic                 eq_o
);

  logic [KEY_BITS-1:0]  key_q;
  logic [DATA_BITS-1:0] data_q;
  logic                 lt_q;
  logic                 eq_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      lt_q <= occ_i && (key_q < search_key_i);
      eq_q <= occ_i && (key_q == search_key_i);
    end
    if (cmd_i.insert && !lt_q) begin
      // first slot not below the key takes the new entry, the rest move up
      if (left_lt_i) begin
        key_q  <= new_key_i;
        data_q <= new_data_i;
      end else begin
        key_q  <= left_key_i;
        data_q <= left_data_i;
      end
    end else if (cmd_i.remove && !lt_q) begin
      key_q  <= right_key_i;
      data_q <= right_data_i;
    end
  end

  assign key_o  = key_q;
  assign data_o = data_q;
  assign lt_o   = lt_q;
  assign eq_o   = eq_q;

endmodule

### rtl/skt_checker.sv
// port-level checks for the sorted key table and their bind
module skt_checker #(
  parameter int CAPACITY  = 64,
  parameter int KEY_BITS  = 32,
  parameter int DATA_BITS = 32
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [1:0]                    operation_i,
  input logic [KEY_BITS-1:0]           search_key_i,
  input logic [DATA_BITS-1:0]          entry_data_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [1:0]                    status_o,
  input logic [DATA_BITS-1:0]          found_data_o,
  input logic [$clog2(CAPACITY)-1:0]   entry_position_o,
  input logic [$clog2(CAPACITY+1)-1:0] entry_count_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(found_data_o) && $stable(entry_position_o) && $stable(entry_count_o))
    else $error("stalled result changed");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while busy");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entry_count_o <= ($clog2(CAPACITY+1))'(CAPACITY))
    else $error("entry count above capacity");

  // failed lookups and full inserts report no position and no data
  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == skt_pkg::ST_MISSING || status_o == skt_pkg::ST_FULL)
      |-> entry_position_o == '0 && found_data_o == '0)
    else $error("miss result carries position or data");

  // full only shows at capacity
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == skt_pkg::ST_FULL
      |-> entry_count_o == ($clog2(CAPACITY+1))'(CAPACITY))
    else $error("full reported below capacity");

endmodule

bind sorted_key_table skt_checker #(
  .CAPACITY (CAPACITY),
  .KEY_BITS (KEY_BITS),
  .DATA_BITS(DATA_BITS)
) u_skt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .operation_i     (operation_i),
  .search_key_i    (search_key_i),
  .entry_data_i    (entry_data_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .found_data_o    (found_data_o),
  .entry_position_o(entry_position_o),
  .entry_count_o   (entry_count_o)
);
